// File: rtl/core/lbs_pkg.sv
// ---------------------------------------------------------------------------
// LED bounce scanner package
// Button codes and timing constants shared by the scanner logic.
// ---------------------------------------------------------------------------
package lbs_pkg;

    // Button codes, compared as the whole active-low byte.
    localparam logic [7:0] BTN_ADJ_UP   = 8'h7F;
    localparam logic [7:0] BTN_ADJ_DOWN = 8'hFE;
    localparam logic [7:0] BTN_REP_UP   = 8'hBF;
    localparam logic [7:0] BTN_REP_DOWN = 8'hFD;
    localparam logic [7:0] BTN_CNT_UP   = 8'hDF;
    localparam logic [7:0] BTN_CNT_DOWN = 8'hFB;
    localparam logic [7:0] BTN_ALL_ON   = 8'hE7;
    localparam logic [7:0] BTN_OFF      = 8'hEF;
    localparam logic [7:0] BTN_HOLD     = 8'hF7;

    localparam int LED_PORT_W = 8;
    localparam int BASE_W     = 6;
    localparam int ADJ_W      = 16;
    localparam int TICK_W     = 16;
    localparam int REP_W      = 8;

    localparam logic [BASE_W-1:0] MIN_PERIOD = 6'd15;
    localparam logic [BASE_W-1:0] BASE_RESET = 6'd50;
    localparam logic signed [ADJ_W-1:0] ADJ_STEP = 16'sd10;
    localparam logic signed [ADJ_W-1:0] ADJ_MAX  = 16'sh7FFF;
    localparam logic signed [ADJ_W-1:0] ADJ_MIN  = 16'sh8000;

    typedef logic [LED_PORT_W-1:0] led_port_t;

endpackage

// File: rtl/core/led_bounce_scanner.sv
// ---------------------------------------------------------------------------
// LED bounce scanner
// One-hot LED that sweeps up and down, blinking at each position, with
// button control of timing, repeats, LED count and forced port patterns.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid, in_stall, buttons_n) carries one beat per
//   millisecond tick with the raw active-low button byte. Output channel
//   (out_valid, out_stall, leds, holding) returns exactly one beat per input
//   beat: the LED port pattern for that tick and the hold flag.
//   The result of an accepted beat is registered in the result register, or
//   in the skid register while the receiver holds the result. The state update
//   is a single pass of logic from the button byte to the state and result
//   registers, so a new beat is accepted in every cycle while in_stall is low.
//   A two-entry output (result register plus skid register) keeps the input
//   open while one result waits. in_stall rises only when both entries are
//   full, that is when a beat arrives while the receiver holds the result.
//   Reset clears the queue and loads the sweep state: position 0 sweeping
//   up, off phase first, 51 ticks to the first phase end, base period 50,
//   adjust 1, one blink per position, and min(4, NUM_LEDS) LEDs in use.
// ---------------------------------------------------------------------------
module led_bounce_scanner #(
    parameter int NUM_LEDS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         buttons_n,
    output logic               out_valid,
    input  logic               out_stall,
    output lbs_pkg::led_port_t leds,
    output logic               holding
);
    import lbs_pkg::*;

    // Position and LED count share one width that can hold NUM_LEDS itself.
    localparam int POS_W     = $clog2(NUM_LEDS + 1);
    localparam int LIT_RESET = (NUM_LEDS < 4) ? NUM_LEDS : 4;

    // Sweep and timing state.
    logic [POS_W-1:0]        led_position_reg, led_position_next;
    logic                    sweeping_down_reg, sweeping_down_next;
    logic [REP_W-1:0]        blink_done_reg, blink_done_next;
    logic                    on_phase_reg, on_phase_next;
    logic [TICK_W-1:0]       ticks_left_reg, ticks_left_next;
    logic [BASE_W-1:0]       base_period_reg, base_period_next;
    logic signed [ADJ_W-1:0] period_adjust_reg, period_adjust_next;
    logic [REP_W-1:0]        repeat_count_reg, repeat_count_next;
    logic [POS_W-1:0]        lit_count_reg, lit_count_next;
    logic                    hold_mode_reg, hold_mode_next;
    led_port_t               led_pattern_reg, led_pattern_next;

    // Output queue: result register and skid register.
    logic                    out_valid_reg;
    led_port_t               out_leds_reg;
    logic                    out_hold_reg;
    logic                    skid_valid_reg;
    led_port_t               skid_leds_reg;
    logic                    skid_hold_reg;

    logic                    in_accept;
    logic                    out_pop;
    logic [TICK_W-1:0]       ticks_dec;
    logic signed [ADJ_W:0]   phase_sum;

    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !skid_valid_reg;
    assign out_pop   = out_valid_reg && !out_stall;

    assign out_valid = out_valid_reg;
    assign leds      = out_leds_reg;
    assign holding   = out_hold_reg;

    // Next state for one tick. The button byte is applied after the phase's
    // own pattern change, so a forced pattern wins at an off phase end and
    // is wiped out by the return to dark at an on phase end.
    always_comb
    begin
        led_position_next  = led_position_reg;
        sweeping_down_next = sweeping_down_reg;
        blink_done_next    = blink_done_reg;
        on_phase_next      = on_phase_reg;
        ticks_left_next    = ticks_left_reg;
        base_period_next   = base_period_reg;
        period_adjust_next = period_adjust_reg;
        repeat_count_next  = repeat_count_reg;
        lit_count_next     = lit_count_reg;
        hold_mode_next     = hold_mode_reg;
        led_pattern_next   = led_pattern_reg;
        ticks_dec          = (ticks_left_reg != '0) ? ticks_left_reg - 1'b1 : ticks_left_reg;
        phase_sum          = '0;

        if (hold_mode_reg)
        begin
            led_pattern_next = '0;
            if (buttons_n == BTN_OFF)
            begin
                hold_mode_next = 1'b0;
            end
        end
        else if (ticks_dec != '0)
        begin
            ticks_left_next = ticks_dec;
        end
        else
        begin
            if (!on_phase_reg)
            begin
                if ((led_position_reg >> 3) == '0)
                begin
                    led_pattern_next = led_port_t'(1) << 3'(led_position_reg);
                end
                else
                begin
                    led_pattern_next = '0;
                end
            end

            case (buttons_n)
                BTN_ADJ_UP:
                begin
                    if (period_adjust_reg > ADJ_MAX - ADJ_STEP)
                        period_adjust_next = ADJ_MAX;
                    else
                        period_adjust_next = period_adjust_reg + ADJ_STEP;
                end
                BTN_ADJ_DOWN:
                begin
                    if (period_adjust_reg < ADJ_MIN + ADJ_STEP)
                        period_adjust_next = ADJ_MIN;
                    else
                        period_adjust_next = period_adjust_reg - ADJ_STEP;
                end
                BTN_REP_UP:
                begin
                    if (repeat_count_reg != '1)
                        repeat_count_next = repeat_count_reg + 1'b1;
                end
                BTN_REP_DOWN:
                begin
                    if (repeat_count_reg <= REP_W'(1))
                        repeat_count_next = REP_W'(1);
                    else
                        repeat_count_next = repeat_count_reg - 1'b1;
                end
                BTN_CNT_UP:
                begin
                    if (lit_count_reg >= POS_W'(NUM_LEDS))
                        lit_count_next = POS_W'(NUM_LEDS);
                    else
                        lit_count_next = lit_count_reg + 1'b1;
                end
                BTN_CNT_DOWN:
                begin
                    if (lit_count_reg <= POS_W'(2))
                        lit_count_next = POS_W'(2);
                    else
                        lit_count_next = lit_count_reg - 1'b1;
                end
                BTN_ALL_ON:
                begin
                    led_pattern_next = '1;
                end
                BTN_OFF:
                begin
                    led_pattern_next = '0;
                end
                BTN_HOLD:
                begin
                    led_pattern_next = '0;
                    hold_mode_next   = 1'b1;
                end
                default:
                begin
                end
            endcase

            if (!on_phase_reg)
            begin
                on_phase_next = 1'b1;
            end
            else
            begin
                if (blink_done_reg != '1)
                    blink_done_next = blink_done_reg + 1'b1;
                if (blink_done_next >= repeat_count_next)
                begin
                    blink_done_next = '0;
                    // Bounce between the ends without showing an end twice.
                    if (!sweeping_down_reg)
                    begin
                        if ({1'b0, led_position_reg} + 1'b1 < {1'b0, lit_count_next})
                        begin
                            led_position_next = led_position_reg + 1'b1;
                        end
                        else if (led_position_reg >= POS_W'(2))
                        begin
                            led_position_next  = led_position_reg - 1'b1;
                            sweeping_down_next = 1'b1;
                        end
                        else
                        begin
                            led_position_next = '0;
                        end
                    end
                    else
                    begin
                        if (led_position_reg >= POS_W'(2))
                        begin
                            led_position_next = led_position_reg - 1'b1;
                        end
                        else
                        begin
                            led_position_next  = '0;
                            sweeping_down_next = 1'b0;
                        end
                    end
                end
                led_pattern_next = '0;
                on_phase_next    = 1'b0;
            end

            // Load the next phase. A phase shorter than the minimum is
            // skipped in a single tick and the timing falls back to MIN_PERIOD, adjust 1.
            phase_sum = $signed({{(ADJ_W + 1 - BASE_W){1'b0}}, base_period_next})
                      + $signed({period_adjust_next[ADJ_W-1], period_adjust_next});
            if (phase_sum < $signed({{(ADJ_W + 1 - BASE_W){1'b0}}, MIN_PERIOD}))
            begin
                base_period_next   = MIN_PERIOD;
                period_adjust_next = ADJ_W'(1);
                ticks_left_next    = TICK_W'(1);
            end
            else
            begin
                ticks_left_next = phase_sum[TICK_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_position_reg  <= '0;
            sweeping_down_reg <= 1'b0;
            blink_done_reg    <= '0;
            on_phase_reg      <= 1'b0;
            ticks_left_reg    <= TICK_W'(BASE_RESET) + 1'b1;
            base_period_reg   <= BASE_RESET;
            period_adjust_reg <= ADJ_W'(1);
            repeat_count_reg  <= REP_W'(1);
            lit_count_reg     <= POS_W'(LIT_RESET);
            hold_mode_reg     <= 1'b0;
            led_pattern_reg   <= '0;
        end
        else if (in_accept)
        begin
            led_position_reg  <= led_position_next;
            sweeping_down_reg <= sweeping_down_next;
            blink_done_reg    <= blink_done_next;
            on_phase_reg      <= on_phase_next;
            ticks_left_reg    <= ticks_left_next;
            base_period_reg   <= base_period_next;
            period_adjust_reg <= period_adjust_next;
            repeat_count_reg  <= repeat_count_next;
            lit_count_reg     <= lit_count_next;
            hold_mode_reg     <= hold_mode_next;
            led_pattern_reg   <= led_pattern_next;
        end
    end

    // Output queue control. The skid entry fills only when a beat arrives
    // while the result register is held by the receiver.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_accept)
        begin
            if (out_valid_reg && !out_pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output queue payload.
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_pop)
            begin
                out_leds_reg <= skid_leds_reg;
                out_hold_reg <= skid_hold_reg;
            end
        end
        else if (in_accept)
        begin
            if (out_valid_reg && !out_pop)
            begin
                skid_leds_reg <= led_pattern_next;
                skid_hold_reg <= hold_mode_next;
            end
            else
            begin
                out_leds_reg <= led_pattern_next;
                out_hold_reg <= hold_mode_next;
            end
        end
    end

endmodule
